// ----- rtl/asws_pkg.sv -----
// Shared constants, types and tables of the actigraphy sleep/wake scorer.
package asws_pkg;

	// Window, log and wake-bout sizing
	localparam int WINDOW_TAPS = 11;
	localparam int WAKE_BOUT   = 5;
	localparam int LOG_DEPTH   = 1024;
	localparam int LOG_AW      = $clog2(LOG_DEPTH);
	localparam int RING_IW     = $clog2(WINDOW_TAPS);
	localparam int STEPS       = (WINDOW_TAPS > WAKE_BOUT + 1) ? WINDOW_TAPS : WAKE_BOUT + 1;
	localparam int STEP_W      = $clog2(STEPS);

	// Datapath widths
	localparam int ACT_W    = 16;
	localparam int WEIGHT_W = 11;
	localparam int PROD_W   = ACT_W + WEIGHT_W;
	localparam int SUM_W    = 29;
	localparam int THR_W    = 32;
	localparam int OFF_W    = 16;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 30;

	// Item commands
	localparam logic CMD_SCORE = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		CFG_DARK_LEVEL      = 3'd0,
		CFG_DIM_LEVEL       = 3'd1,
		CFG_MODERATE_LEVEL  = 3'd2,
		CFG_BASE_THRESHOLD  = 3'd3,
		CFG_OFFSET_DARK     = 3'd4,
		CFG_OFFSET_DIM      = 3'd5,
		CFG_OFFSET_MODERATE = 3'd6,
		CFG_OFFSET_BRIGHT   = 3'd7
	} cfg_reg_t;

	// Light classes
	typedef enum logic [1:0] {
		LC_DARK     = 2'd0,
		LC_DIM      = 2'd1,
		LC_MODERATE = 2'd2,
		LC_BRIGHT   = 2'd3
	} lux_class_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic              load;
		logic              step;
		logic [STEP_W-1:0] step_idx;
		logic              finish;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	// Window weights, oldest to newest
	function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [STEP_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			0: w = 11'd404;
			1: w = 11'd598;
			2: w = 11'd326;
			3: w = 11'd441;
			4: w = 11'd1408;
			5: w = 11'd598;
			6: w = 11'd326;
			7: w = 11'd441;
			8: w = 11'd404;
			9: w = 11'd598;
			default: w = 11'd0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/asws_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module asws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               command,
	output logic               in_ready,
	input  asws_pkg::dp_stat_t stat,
	output asws_pkg::dp_cmd_t  cmd
);

	asws_pkg::ctl_state_t           state_q, state_n;
	logic [asws_pkg::STEP_W-1:0]    cnt_q, cnt_n;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asws_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n      = state_q;
		cnt_n        = cnt_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.step_idx = cnt_q;
		cmd.finish   = 1'b0;
		case (state_q)
			asws_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_n    = '0;
					state_n  = (command == asws_pkg::CMD_START) ? asws_pkg::ST_FINISH
					                                           : asws_pkg::ST_RUN;
				end
			end
			asws_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (cnt_q == asws_pkg::STEP_W'(asws_pkg::STEPS - 1)) begin
					state_n = asws_pkg::ST_DRAIN;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			asws_pkg::ST_DRAIN: begin
				state_n = asws_pkg::ST_FINISH;
			end
			asws_pkg::ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_n    = asws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = asws_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/asws_dp.sv -----
// Datapath: config registers, activity window, weighted sum, epoch log and session counters.
module asws_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asws_pkg::dp_cmd_t             cmd,
	output asws_pkg::dp_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [asws_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [asws_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          command,
	input  logic [asws_pkg::ACT_W-1:0]    motion_count,
	input  logic [7:0]                    lux_level,
	input  logic [31:0]                   timestamp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          asleep,
	output logic [1:0]                    lux_class,
	output logic [15:0]                   sleep_minutes,
	output logic [15:0]                   wake_minutes,
	output logic [15:0]                   dark_sleep_minutes,
	output logic [7:0]                    awakenings,
	output logic [31:0]                   onset_time,
	output logic [31:0]                   offset_time
);

	// Configuration registers
	logic [7:0]                        dark_level_q, dim_level_q, moderate_level_q;
	logic [asws_pkg::CFG_DW-1:0]       base_q;
	logic [asws_pkg::OFF_W-1:0]        off_dark_q, off_dim_q, off_mod_q, off_bright_q;

	// Window and sequencing state
	logic [asws_pkg::ACT_W-1:0]        ring_q [asws_pkg::WINDOW_TAPS];
	logic [asws_pkg::RING_IW-1:0]      pos_q, pos_next, rd_q;
	logic [asws_pkg::LOG_AW-1:0]       epoch_q, log_raddr;
	logic                              log_mem [asws_pkg::LOG_DEPTH];

	// Per-item working registers
	logic                              cmd_q;
	logic [31:0]                       ts_q;
	asws_pkg::lux_class_t              cls_q, cls_n;
	logic [asws_pkg::OFF_W-1:0]        off_sel;
	logic signed [asws_pkg::THR_W-1:0] thr_q;
	logic [asws_pkg::SUM_W-1:0]        acc_q;
	logic                              run_q, prior_q;

	// Multiply stage
	logic [asws_pkg::PROD_W-1:0]       mult;
	logic [asws_pkg::PROD_W-1:0]       prod_s1;
	logic [asws_pkg::STEP_W-1:0]       idx_s1;
	logic                              valid_s1;
	logic                              log_rd_s1;

	// Session state and result
	logic [15:0]                       sleep_q, wake_q, dark_q;
	logic [7:0]                        awake_q;
	logic [31:0]                       first_q, last_q;
	logic                              asleep_q, out_valid_q;
	asws_pkg::lux_class_t              cls_out_q;
	logic                              asleep_n, score_fin, clear_fin, awaken;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_level_q     <= 8'd10;
			dim_level_q      <= 8'd50;
			moderate_level_q <= 8'd150;
			base_q           <= 30'd1000;
			off_dark_q       <= -16'sd200;
			off_dim_q        <= -16'sd50;
			off_mod_q        <= 16'sd100;
			off_bright_q     <= 16'sd400;
		end else if (cfg_we) begin
			case (asws_pkg::cfg_reg_t'(cfg_index))
				asws_pkg::CFG_DARK_LEVEL:      dark_level_q     <= cfg_data[7:0];
				asws_pkg::CFG_DIM_LEVEL:       dim_level_q      <= cfg_data[7:0];
				asws_pkg::CFG_MODERATE_LEVEL:  moderate_level_q <= cfg_data[7:0];
				asws_pkg::CFG_BASE_THRESHOLD:  base_q           <= cfg_data;
				asws_pkg::CFG_OFFSET_DARK:     off_dark_q       <= cfg_data[15:0];
				asws_pkg::CFG_OFFSET_DIM:      off_dim_q        <= cfg_data[15:0];
				asws_pkg::CFG_OFFSET_MODERATE: off_mod_q        <= cfg_data[15:0];
				asws_pkg::CFG_OFFSET_BRIGHT:   off_bright_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Classify light and pick the threshold offset
	always_comb begin
		if (lux_level < dark_level_q) begin
			cls_n   = asws_pkg::LC_DARK;
			off_sel = off_dark_q;
		end else if (lux_level < dim_level_q) begin
			cls_n   = asws_pkg::LC_DIM;
			off_sel = off_dim_q;
		end else if (lux_level < moderate_level_q) begin
			cls_n   = asws_pkg::LC_MODERATE;
			off_sel = off_mod_q;
		end else begin
			cls_n   = asws_pkg::LC_BRIGHT;
			off_sel = off_bright_q;
		end
	end

	assign pos_next  = (pos_q == asws_pkg::RING_IW'(asws_pkg::WINDOW_TAPS - 1)) ? '0 : pos_q + 1'b1;
	assign mult      = ring_q[rd_q] * asws_pkg::tap_weight(cmd.step_idx);
	assign log_raddr = epoch_q - asws_pkg::LOG_AW'(1) - asws_pkg::LOG_AW'(cmd.step_idx);

	// Finish decision
	assign score_fin = cmd.finish && (cmd_q == asws_pkg::CMD_SCORE);
	assign clear_fin = cmd.finish && (cmd_q == asws_pkg::CMD_START);
	assign asleep_n  = $signed({{(asws_pkg::THR_W - asws_pkg::SUM_W){1'b0}}, acc_q}) < thr_q;
	assign awaken    = !asleep_n && (epoch_q > asws_pkg::LOG_AW'(asws_pkg::WAKE_BOUT))
	                   && run_q && prior_q && (awake_q != 8'hFF);

	// Capture the item, latch timestamp, class and threshold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			ts_q  <= timestamp;
			cls_q <= cls_n;
			thr_q <= $signed({2'b00, base_q})
			         + $signed({{(asws_pkg::THR_W - asws_pkg::OFF_W){off_sel[asws_pkg::OFF_W-1]}},
			                    off_sel});
		end
	end

	// Multiply one tap and read one log bit per step; write the epoch's score to the log on finish
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			prod_s1   <= (cmd.step_idx < asws_pkg::STEP_W'(asws_pkg::WINDOW_TAPS)) ? mult : '0;
			idx_s1    <= cmd.step_idx;
			log_rd_s1 <= log_mem[log_raddr];
		end
		if (score_fin) begin
			log_mem[epoch_q] <= asleep_n;
		end
	end

	// Accumulate products and scan the wake run
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q   <= '0;
			run_q   <= 1'b1;
			prior_q <= 1'b0;
		end else if (valid_s1) begin
			acc_q <= acc_q + {{(asws_pkg::SUM_W - asws_pkg::PROD_W){1'b0}}, prod_s1};
			if (idx_s1 < asws_pkg::STEP_W'(asws_pkg::WAKE_BOUT)) begin
				run_q <= run_q & ~log_rd_s1;
			end
			if (idx_s1 == asws_pkg::STEP_W'(asws_pkg::WAKE_BOUT)) begin
				prior_q <= log_rd_s1;
			end
		end
	end

	// Window pointers, ring and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < asws_pkg::WINDOW_TAPS; i++) ring_q[i] <= '0;
			pos_q     <= '0;
			rd_q      <= '0;
			valid_s1  <= 1'b0;
			epoch_q   <= '0;
			sleep_q   <= '0;
			wake_q    <= '0;
			dark_q    <= '0;
			awake_q   <= '0;
			first_q   <= '0;
			last_q    <= '0;
			asleep_q  <= 1'b0;
			cls_out_q <= asws_pkg::LC_DARK;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			// Push the count and point the read pointer at the oldest entry
			if (cmd.load && command == asws_pkg::CMD_SCORE) begin
				ring_q[pos_q] <= motion_count;
				pos_q         <= pos_next;
				rd_q          <= pos_next;
			end else if (cmd.step) begin
				rd_q <= (rd_q == asws_pkg::RING_IW'(asws_pkg::WINDOW_TAPS - 1)) ? '0 : rd_q + 1'b1;
			end
			// Drop the session on a start item
			if (clear_fin) begin
				for (int i = 0; i < asws_pkg::WINDOW_TAPS; i++) ring_q[i] <= '0;
				pos_q     <= '0;
				epoch_q   <= '0;
				sleep_q   <= '0;
				wake_q    <= '0;
				dark_q    <= '0;
				awake_q   <= '0;
				first_q   <= '0;
				last_q    <= '0;
				asleep_q  <= 1'b0;
				cls_out_q <= asws_pkg::LC_DARK;
			end
			// Score the epoch and advance the counters
			if (score_fin) begin
				asleep_q  <= asleep_n;
				cls_out_q <= cls_q;
				epoch_q   <= (epoch_q == asws_pkg::LOG_AW'(asws_pkg::LOG_DEPTH - 1)) ? '0 : epoch_q + 1'b1;
				if (asleep_n) begin
					if (first_q == 32'd0) first_q <= ts_q;
					last_q <= ts_q;
					if (sleep_q != 16'hFFFF) sleep_q <= sleep_q + 1'b1;
					if (cls_q == asws_pkg::LC_DARK && dark_q != 16'hFFFF) dark_q <= dark_q + 1'b1;
				end else begin
					if (wake_q != 16'hFFFF) wake_q <= wake_q + 1'b1;
					if (awaken) awake_q <= awake_q + 1'b1;
				end
			end
			// Hold the result until taken
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy      = out_valid_q && !out_ready;
	assign out_valid          = out_valid_q;
	assign asleep             = asleep_q;
	assign lux_class          = cls_out_q;
	assign sleep_minutes      = sleep_q;
	assign wake_minutes       = wake_q;
	assign dark_sleep_minutes = dark_q;
	assign awakenings         = awake_q;
	assign onset_time         = first_q;
	assign offset_time        = last_q;

endmodule

// ----- rtl/actigraphy_sleep_wake_scorer_top.sv -----
// Actigraphy sleep/wake scorer: one item is taken at a time. A scoring item steps through the
// RUN, DRAIN and FINISH states before its result is valid and the next item is taken; a start
// item goes straight to FINISH. The single shared tap multiplier walks the 11-entry window,
// one tap per cycle, while the epoch log is read one bit per cycle alongside.
// Reset loads the register defaults and clears window, counters and times at once;
// the epoch log needs no clearing pass and an item can be taken right after reset.
module actigraphy_sleep_wake_scorer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [asws_pkg::CFG_IW-1:0] cfg_index,
	input  logic [asws_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [15:0]                 motion_count,
	input  logic [7:0]                  lux_level,
	input  logic [31:0]                 timestamp,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        asleep,
	output logic [1:0]                  lux_class,
	output logic [15:0]                 sleep_minutes,
	output logic [15:0]                 wake_minutes,
	output logic [15:0]                 dark_sleep_minutes,
	output logic [7:0]                  awakenings,
	output logic [31:0]                 onset_time,
	output logic [31:0]                 offset_time
);

	asws_pkg::dp_cmd_t  cmd;
	asws_pkg::dp_stat_t stat;

	// Sequencer
	asws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Scoring datapath
	asws_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.command            (command),
		.motion_count       (motion_count),
		.lux_level          (lux_level),
		.timestamp          (timestamp),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.asleep             (asleep),
		.lux_class          (lux_class),
		.sleep_minutes      (sleep_minutes),
		.wake_minutes       (wake_minutes),
		.dark_sleep_minutes (dark_sleep_minutes),
		.awakenings         (awakenings),
		.onset_time         (onset_time),
		.offset_time        (offset_time)
	);

endmodule
